// ----- rtl/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, letter codes and token table of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int VALUE_W  = 12;
	localparam int LETTER_W = 8;
	localparam int TOK_W    = 4;

	// ASCII codes of the numeral letters
	localparam logic [LETTER_W-1:0] CH_I = 8'h49;
	localparam logic [LETTER_W-1:0] CH_V = 8'h56;
	localparam logic [LETTER_W-1:0] CH_X = 8'h58;
	localparam logic [LETTER_W-1:0] CH_L = 8'h4C;
	localparam logic [LETTER_W-1:0] CH_C = 8'h43;
	localparam logic [LETTER_W-1:0] CH_D = 8'h44;
	localparam logic [LETTER_W-1:0] CH_M = 8'h4D;

	// Token indices, greedy order
	typedef enum logic [TOK_W-1:0] {
		TK_M  = 4'd0,
		TK_CM = 4'd1,
		TK_D  = 4'd2,
		TK_CD = 4'd3,
		TK_C  = 4'd4,
		TK_XC = 4'd5,
		TK_L  = 4'd6,
		TK_XL = 4'd7,
		TK_X  = 4'd8,
		TK_IX = 4'd9,
		TK_V  = 4'd10,
		TK_IV = 4'd11,
		TK_I  = 4'd12
	} i2r_tok_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic busy;
	} i2r_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;
		logic hit;
		logic slot_free;
	} i2r_stat_t;

	function automatic logic [VALUE_W-1:0] tok_weight(input i2r_tok_t t);
		logic [VALUE_W-1:0] w;
		unique case (t)
			TK_M:    w = 12'd1000;
			TK_CM:   w = 12'd900;
			TK_D:    w = 12'd500;
			TK_CD:   w = 12'd400;
			TK_C:    w = 12'd100;
			TK_XC:   w = 12'd90;
			TK_L:    w = 12'd50;
			TK_XL:   w = 12'd40;
			TK_X:    w = 12'd10;
			TK_IX:   w = 12'd9;
			TK_V:    w = 12'd5;
			TK_IV:   w = 12'd4;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	// First letter of a token
	function automatic logic [LETTER_W-1:0] tok_first(input i2r_tok_t t);
		logic [LETTER_W-1:0] c;
		unique case (t)
			TK_M:    c = CH_M;
			TK_CM:   c = CH_C;
			TK_D:    c = CH_D;
			TK_CD:   c = CH_C;
			TK_C:    c = CH_C;
			TK_XC:   c = CH_X;
			TK_L:    c = CH_L;
			TK_XL:   c = CH_X;
			TK_X:    c = CH_X;
			TK_IX:   c = CH_I;
			TK_V:    c = CH_V;
			TK_IV:   c = CH_I;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	// Second letter of a two-letter token
	function automatic logic [LETTER_W-1:0] tok_second(input i2r_tok_t t);
		logic [LETTER_W-1:0] c;
		unique case (t)
			TK_CM:   c = CH_M;
			TK_CD:   c = CH_D;
			TK_XC:   c = CH_C;
			TK_XL:   c = CH_L;
			TK_IX:   c = CH_X;
			TK_IV:   c = CH_V;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	function automatic logic tok_pair(input i2r_tok_t t);
		return (t == TK_CM) || (t == TK_CD) || (t == TK_XC) ||
		       (t == TK_XL) || (t == TK_IX) || (t == TK_IV);
	endfunction

endpackage

// ----- rtl/i2r_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2r_ctrl
// Sequencer: takes a value when idle and steps the datapath until it is spent.
// ----------------------------------------------------------------------------
module i2r_ctrl import i2r_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  i2r_stat_t stat,
	output i2r_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} i2r_state_t;

	i2r_state_t state_q;
	i2r_state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.busy = 1'b1;
				// hold while a letter is due but the output slot is full
				cmd.step = !stat.done && (!stat.hit || stat.slot_free);
				if (stat.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/i2r_datapath.sv -----
// ----------------------------------------------------------------------------
// i2r_datapath
// Remainder, token pointer, letter position and the output word register.
// ----------------------------------------------------------------------------
module i2r_datapath import i2r_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  i2r_cmd_t            cmd,
	input  logic [VALUE_W-1:0]  value,
	input  logic                rsp_stall,
	output i2r_stat_t           stat,
	output logic                rsp_valid,
	output logic [LETTER_W-1:0] letter,
	output logic                last
);

	logic [VALUE_W-1:0]  rest_q;
	i2r_tok_t            tok_q;
	logic                pos_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;

	logic [VALUE_W-1:0]  weight;
	logic                hit;
	logic                tok_end;
	logic                emit;
	logic [LETTER_W-1:0] ch;

	assign weight  = tok_weight(tok_q);
	assign hit     = rest_q >= weight;
	assign tok_end = !tok_pair(tok_q) || pos_q;
	assign ch      = pos_q ? tok_second(tok_q) : tok_first(tok_q);
	assign emit    = cmd.step && hit;

	assign stat.done      = (rest_q == '0);
	assign stat.hit       = hit;
	assign stat.slot_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
			tok_q  <= TK_M;
			pos_q  <= 1'b0;
		end else if (cmd.step) begin
			if (hit) begin
				if (tok_end) begin
					rest_q <= rest_q - weight;
					pos_q  <= 1'b0;
				end else begin
					pos_q <= 1'b1;
				end
			end else begin
				tok_q <= i2r_tok_t'(tok_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			letter_q <= ch;
			last_q   <= tok_end && (rest_q == weight);
		end
	end

	assign rsp_valid = out_valid_q;
	assign letter    = letter_q;
	assign last      = last_q;

endmodule

// ----- rtl/int_to_roman_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// int_to_roman_encoder_unit
// Converts a 12-bit unsigned value into its Roman numeral, one ASCII letter
// per output word, with the final letter marked.
// ----------------------------------------------------------------------------
// A value word is taken on req_* and its numeral leaves on rsp_* as a run of
// letter words (I, V, X, L, C, D, M), with last high on the final one. The
// conversion is greedy over the thirteen tokens M, CM, D, CD, C, XC, L, XL,
// X, IX, V, IV, I; thousands above three repeat M, and zero gives no words.
// One value is converted at a time: the controller walks a single
// compare-and-subtract unit down the token table, sending a letter on each
// step that hits and passing over the token on each step that misses (at
// most twelve are passed over), then retiring the value once the remainder
// is spent (3888, fifteen letters, has the longest numeral). Output stall
// holds the walk while a letter is due and the output register is held full.
// req_stall is high while a value is in work, and a new value may be taken
// while the last letter of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
module int_to_roman_encoder_unit import i2r_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [VALUE_W-1:0]  value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [LETTER_W-1:0] letter,
	output logic                last
);

	i2r_cmd_t  cmd;
	i2r_stat_t stat;

	// sequencer: accept when idle, step until the remainder is spent
	i2r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// remainder, token walk and the output word register
	i2r_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.letter    (letter),
		.last      (last)
	);

	// hold off new values while one is in work
	assign req_stall = cmd.busy;

	// an accepted value always puts the sequencer to work next cycle
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> cmd.busy)
		else $error("accepted value did not start a conversion");

	// a fresh output word can only come from a running conversion
	a_word_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (!$past(rsp_valid) || !$past(rsp_stall)) && $past(arst_n)
		|-> $past(cmd.busy))
		else $error("output word appeared without a conversion running");

	// every word is a numeral letter
	a_letter_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (letter == CH_I) || (letter == CH_V) || (letter == CH_X) ||
		              (letter == CH_L) || (letter == CH_C) || (letter == CH_D) ||
		              (letter == CH_M))
		else $error("output word is not a numeral letter");

	// a letter is only sent when the output slot can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && stat.hit |-> stat.slot_free)
		else $error("letter sent into a full output register");

endmodule
